/* rtl/spectral_peak_picker_unit_defines.svh */
// Assertion macros shared by the spectral peak picker RTL.
`ifndef SPECTRAL_PEAK_PICKER_UNIT_DEFINES_SVH
`define SPECTRAL_PEAK_PICKER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spp: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spp: next-cycle check failed");

`endif

/* rtl/spp_pkg.sv */
// Types, constants and the log fraction table of the spectral peak picker.
`timescale 1ns / 1ps
package spp_pkg;

  localparam int unsigned LOG_TABLE_SIZE  = 256;
  localparam int unsigned LOG_IDX_W       = $clog2(LOG_TABLE_SIZE);
  localparam int unsigned WIN_LEN         = 11;
  localparam int unsigned HALF            = 5;
  localparam int unsigned JOB_QUEUE_DEPTH = 2;
  localparam logic [28:0] LN2_OVER_10_Q32 = 29'd297704447;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_FLOOR = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAIN   = 4'd7;

  typedef logic [16:0] log_tab_t [0:LOG_TABLE_SIZE];

  // log2(1+i/size) in Q1.16 by repeated squaring, last entry is one
  function automatic log_tab_t build_log_tab();
    log_tab_t          tab;
    longint unsigned   y;
    logic [16:0]       bits;
    for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
      y    = (64'd1 << 30) + ((64'(i)) << 30) / LOG_TABLE_SIZE;
      bits = '0;
      for (int k = 0; k < 16; k++) begin
        y    = (y * y) >> 30;
        bits = {bits[15:0], 1'b0};
        if (y >= (64'd1 << 31)) begin
          y       = y >> 1;
          bits[0] = 1'b1;
        end
      end
      tab[i] = bits;
    end
    tab[LOG_TABLE_SIZE] = 17'd65536;
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  typedef struct packed {
    logic [23:0] magnitude;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [15:0] log_level;
    logic [15:0] smoothed_level;
    logic [15:0] peak_strength;
    logic        is_peak;
    logic        frame_done;
  } result_t;

  typedef struct packed {
    logic [HALF:0][15:0] coef;
    logic [15:0]         ratio_floor;
    logic [15:0]         peak_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coef:        {16'd574, 16'd1769, 16'd4244, 16'd7929, 16'd11537, 16'd13073},
    ratio_floor: 16'd16,
    peak_gain:   16'd3277
  };

  // One emit request: the 11 levels around the bin, oldest at index 0
  typedef struct packed {
    logic [WIN_LEN-1:0][15:0] win;
    logic [7:0]               bin;
    logic                     last;
  } job_t;

endpackage

/* rtl/spp_front.sv */
// Front end: log compression, level window and emit request generation.
`timescale 1ns / 1ps
module spp_front #(
  parameter int unsigned MAX_BINS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spp_pkg::in_item_t item_i,
  output logic            full_o,
  output spp_pkg::job_t   job_o,
  output logic            job_push_o,
  input  logic            job_full_i
);
  import spp_pkg::*;

  localparam logic [2:0] FS_IDLE = 3'd0;
  localparam logic [2:0] FS_NORM = 3'd1;
  localparam logic [2:0] FS_TAB  = 3'd2;
  localparam logic [2:0] FS_SUM  = 3'd3;
  localparam logic [2:0] FS_MUL  = 3'd4;
  localparam logic [2:0] FS_EMIT = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [23:0] mag_q, mag_d;
  logic        fend_q, fend_d;
  logic [4:0]  p_q, p_d;
  logic [LOG_IDX_W-1:0] idx_q, idx_d;
  logic [15:0] frac_q, frac_d;
  logic [16:0] t0_q, t0_d;
  logic [32:0] mul_q, mul_d;
  logic [21:0] lg_q, lg_d;
  logic [WIN_LEN-1:0][15:0] win_q, win_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  d_q, d_d;
  logic        end_q, end_d;

  logic [24:0] x;
  logic [4:0]  lead;
  logic [24:0] norm;
  logic [16:0] t1;
  logic [51:0] lvl_prod;
  logic [8:0]  pos;
  logic        want;
  logic        proceed;

  always_comb begin
    x    = 25'(mag_q) + 25'd1;
    lead = '0;
    for (int i = 0; i < 25; i++) begin
      if (x[i]) lead = 5'(i);
    end
    norm     = x << (5'd24 - lead);
    t1       = LOG_TAB[{1'b0, idx_q} + 9'd1];
    lvl_prod = 52'(lg_q) * 52'(LN2_OVER_10_Q32) + (52'd1 << 33);
    pos      = 9'(cnt_q) + 9'(d_q);
    want     = pos >= 9'(HALF);
    proceed  = !want || !job_full_i;
  end

  assign full_o          = state_q != FS_IDLE;
  assign job_push_o      = state_q == FS_EMIT && want && !job_full_i;
  assign job_o.win       = win_q;
  assign job_o.bin       = 8'(pos - 9'(HALF));
  assign job_o.last      = end_q && d_q == 3'(HALF);

  // Advance the per-item sequence
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    fend_d  = fend_q;
    p_d     = p_q;
    idx_d   = idx_q;
    frac_d  = frac_q;
    t0_d    = t0_q;
    mul_d   = mul_q;
    lg_d    = lg_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    d_d     = d_q;
    end_d   = end_q;
    case (state_q)
      FS_IDLE: begin
        if (push_i) begin
          mag_d   = item_i.magnitude;
          fend_d  = item_i.frame_end;
          state_d = FS_NORM;
        end
      end
      FS_NORM: begin
        p_d     = lead;
        idx_d   = norm[23:16];
        frac_d  = norm[15:0];
        state_d = FS_TAB;
      end
      FS_TAB: begin
        t0_d    = LOG_TAB[idx_q];
        mul_d   = 33'(t1 - LOG_TAB[idx_q]) * 33'(frac_q);
        state_d = FS_SUM;
      end
      FS_SUM: begin
        lg_d    = 22'({p_q, 16'd0}) + 22'(t0_q) + 22'(mul_q[32:16]);
        state_d = FS_MUL;
      end
      FS_MUL: begin
        win_d   = {lvl_prod[49:34], win_q[WIN_LEN-1:1]};
        end_d   = fend_q || cnt_q >= 8'(MAX_BINS - 1);
        d_d     = '0;
        state_d = FS_EMIT;
      end
      FS_EMIT: begin
        if (proceed) begin
          if (!end_q) begin
            cnt_d   = cnt_q + 8'd1;
            state_d = FS_IDLE;
          end else if (d_q == 3'(HALF)) begin
            win_d   = '0;
            cnt_d   = '0;
            state_d = FS_IDLE;
          end else begin
            win_d = {16'd0, win_q[WIN_LEN-1:1]};
            d_d   = d_q + 3'd1;
          end
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      win_q   <= '0;
      cnt_q   <= '0;
      d_q     <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      d_q     <= d_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    fend_q <= fend_d;
    p_q    <= p_d;
    idx_q  <= idx_d;
    frac_q <= frac_d;
    t0_q   <= t0_d;
    mul_q  <= mul_d;
    lg_q   <= lg_d;
  end

endmodule

/* rtl/spp_queue.sv */
// Short queue of emit requests between front and back.
`timescale 1ns / 1ps
module spp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spp_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output spp_pkg::job_t data_o,
  output logic          empty_o
);
  import spp_pkg::*;

  localparam int unsigned PTR_W = $clog2(JOB_QUEUE_DEPTH);

  job_t             slot_q [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (PTR_W + 1)'(JOB_QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rptr_q];

  // Track fill level and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PTR_W'(1);
      if (pop_i)  rptr_q <= rptr_q + PTR_W'(1);
      cnt_q <= cnt_q + (PTR_W + 1)'(push_i) - (PTR_W + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= data_i;
  end

endmodule

/* rtl/spp_back.sv */
// Back end: Gaussian smoothing, peak test, ratio division and result register.
`timescale 1ns / 1ps
module spp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spp_pkg::cfg_t    cfg_i,
  input  spp_pkg::job_t    job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  input  logic             out_pop_i,
  output logic             out_empty_o,
  output spp_pkg::result_t result_o
);
  import spp_pkg::*;

  localparam logic [2:0] BS_IDLE = 3'd0;
  localparam logic [2:0] BS_MAC  = 3'd1;
  localparam logic [2:0] BS_RND  = 3'd2;
  localparam logic [2:0] BS_DIV  = 3'd3;
  localparam logic [2:0] BS_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  job_t        job_q, job_d;
  logic [3:0]  k_q, k_d;
  logic [35:0] acc_q, acc_d;
  logic [15:0] sm_q, sm_d;
  logic        peak_q, peak_d;
  logic [31:0] num_q, num_d;
  logic [20:0] dvs_q, dvs_d;
  logic [20:0] rem_q, rem_d;
  logic [4:0]  it_q, it_d;
  result_t     out_q, out_d;
  logic        ovld_q, ovld_d;

  logic [2:0]  ci;
  logic [31:0] tap_prod;
  logic [36:0] rnd;
  logic [15:0] sm;
  logic [15:0] lvl;
  logic        peak;
  logic [16:0] den;
  logic [15:0] exc;
  logic [21:0] rem_sh;
  logic        qbit;

  always_comb begin
    ci       = (k_q < 4'(HALF)) ? 3'(4'(HALF) - k_q) : 3'(k_q - 4'(HALF));
    tap_prod = 32'(cfg_i.coef[ci]) * 32'(job_q.win[k_q]);
    rnd      = 37'(acc_q) + 37'd32768;
    sm       = (|rnd[36:32]) ? 16'hFFFF : rnd[31:16];
    lvl      = job_q.win[HALF];
    peak     = job_q.bin != 8'd0 && !job_q.last &&
               lvl > job_q.win[HALF-1] && lvl > job_q.win[HALF+1];
    den      = 17'(cfg_i.ratio_floor) + 17'(sm);
    exc      = lvl - den[15:0];
    rem_sh   = {rem_q, num_q[31]};
    qbit     = rem_sh >= {1'b0, dvs_q};
  end

  assign job_pop_o   = state_q == BS_IDLE && !job_empty_i;
  assign out_empty_o = !ovld_q;
  assign result_o    = out_q;

  // Step through smoothing, division and hand-off
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    k_d     = k_q;
    acc_d   = acc_q;
    sm_d    = sm_q;
    peak_d  = peak_q;
    num_d   = num_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    it_d    = it_q;
    out_d   = out_q;
    ovld_d  = ovld_q && !out_pop_i;
    case (state_q)
      BS_IDLE: begin
        if (!job_empty_i) begin
          job_d   = job_i;
          k_d     = '0;
          acc_d   = '0;
          state_d = BS_MAC;
        end
      end
      BS_MAC: begin
        acc_d = acc_q + 36'(tap_prod);
        k_d   = k_q + 4'd1;
        if (k_q == 4'(WIN_LEN - 1)) state_d = BS_RND;
      end
      BS_RND: begin
        sm_d   = sm;
        peak_d = peak;
        if (peak && 17'(lvl) > den) begin
          if (den == '0) begin
            num_d   = (cfg_i.peak_gain != '0) ? 32'h0000_FFFF : '0;
            state_d = BS_OUT;
          end else begin
            num_d   = 32'(cfg_i.peak_gain) * 32'(exc);
            dvs_d   = {den, 4'd0};
            rem_d   = '0;
            it_d    = '0;
            state_d = BS_DIV;
          end
        end else begin
          num_d   = '0;
          state_d = BS_OUT;
        end
      end
      BS_DIV: begin
        rem_d = qbit ? 21'(rem_sh - {1'b0, dvs_q}) : rem_sh[20:0];
        num_d = {num_q[30:0], qbit};
        it_d  = it_q + 5'd1;
        if (it_q == 5'd31) state_d = BS_OUT;
      end
      BS_OUT: begin
        if (!ovld_q || out_pop_i) begin
          out_d.bin_index      = job_q.bin;
          out_d.log_level      = lvl;
          out_d.smoothed_level = sm_q;
          out_d.peak_strength  = (|num_q[31:16]) ? 16'hFFFF : num_q[15:0];
          out_d.is_peak        = peak_q;
          out_d.frame_done     = job_q.last;
          ovld_d               = 1'b1;
          state_d              = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      ovld_q  <= 1'b0;
      k_q     <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      k_q     <= k_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    acc_q  <= acc_d;
    sm_q   <= sm_d;
    peak_q <= peak_d;
    num_q  <= num_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

endmodule

/* rtl/spectral_peak_picker_unit.sv */
// Top level of the spectral peak picker: config registers, front, queue, back.
//
//  channel   direction  transfer when            payload
//  input     in         push & !full             item_i (magnitude, frame_end)
//  result    out        pop & !empty             result_o (bin, levels, peak)
//  config    in         cfg_valid_i & ready      cfg_index_i, cfg_data_i
//
//  The front takes no new bin until it has finished the last one; a frame's
//  last bin walks six emit steps and keeps full high throughout.
//  The back smooths every result with the 11-tap multiply-accumulate and runs
//  the 32-step restoring divider only for a peak.
//  Reset clears control state and the window; no clearing pass is needed.
//  A full job queue stalls the front; a waiting result stalls the back.
`timescale 1ns / 1ps
module spectral_peak_picker_unit #(
  parameter int unsigned MAX_BINS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  spp_pkg::in_item_t                 item_i,
  input  logic                              pop,
  output logic                              empty,
  output spp_pkg::result_t                  result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import spp_pkg::*;
  `include "spectral_peak_picker_unit_defines.svh"

  cfg_t cfg_q;
  job_t fr_job, q_job;
  logic job_push, job_full, job_pop, job_empty;

  assign cfg_ready_o = 1'b1;

  // Hold configuration, drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i <= CFG_COEF_LAST) begin
        cfg_q.coef[cfg_index_i[2:0]] <= cfg_data_i;
      end else begin
        case (cfg_index_i)
          CFG_RATIO_FLOOR: cfg_q.ratio_floor <= cfg_data_i;
          CFG_PEAK_GAIN:   cfg_q.peak_gain   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  spp_front #(
    .MAX_BINS(MAX_BINS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .job_o      (fr_job),
    .job_push_o (job_push),
    .job_full_i (job_full)
  );

  spp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (fr_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (q_job),
    .empty_o (job_empty)
  );

  spp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (q_job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .result_o    (result_o)
  );

  `SPP_ASSERT_NOW(a_peak_not_last, !empty && result_o.is_peak, !result_o.frame_done)
  `SPP_ASSERT_NOW(a_strength_needs_peak, !empty && result_o.peak_strength != 16'd0, result_o.is_peak)
  `SPP_ASSERT_NOW(a_peak_not_first, !empty && result_o.is_peak, result_o.bin_index != 8'd0)
  `SPP_ASSERT_NEXT(a_busy_after_accept, push && !full, full)

endmodule
